FILE: hw/rtl/cwcr_pkg.sv
// contact wrench cone residual: shared types, constants and the cone table
// used by the interfaces, the rotation stage and the top level; no dependencies
package cwcr_pkg;

  localparam int NumRows   = 17;
  localparam int WrenchDim = 6;
  localparam int QuatW     = 16;
  localparam int RowW      = 5;
  localparam int OutW      = 40;
  localparam int CfgW      = 16;
  localparam int CfgIdxW   = 2;
  localparam int VecW      = 64;
  localparam int AccW      = 104;
  localparam int CoefFrac  = 30;
  localparam int CoefW     = 33;
  localparam int PpW       = 67;

  localparam logic [RowW-1:0] LastRow = RowW'(NumRows - 1);

  // wrench columns
  localparam int ColTx = 0;
  localparam int ColTy = 1;
  localparam int ColTz = 2;
  localparam int ColFx = 3;
  localparam int ColFy = 4;
  localparam int ColFz = 5;

  // scaled products formed once per word
  localparam int NumProd = 8;
  localparam int PrMtx = 0;
  localparam int PrMty = 1;
  localparam int PrMfz = 2;
  localparam int PrXfy = 3;
  localparam int PrXfz = 4;
  localparam int PrYfx = 5;
  localparam int PrYfz = 6;
  localparam int PrKfz = 7;
  localparam int PrShift [NumProd] = '{16, 16, 16, 14, 14, 14, 14, 0};

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRICTION = 2'd0,
    REG_X_HALF   = 2'd1,
    REG_Y_HALF   = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    CF_ZERO, CF_P1, CF_N1, CF_PMU, CF_NMU, CF_PX, CF_NX, CF_PY, CF_NY, CF_MXY
  } coef_e;

  typedef logic signed [AccW-1:0] acc_t;
  typedef logic [WrenchDim-1:0][VecW-1:0] wrench_vec_t;

  localparam coef_e ConeCode [NumRows][WrenchDim] = '{
    '{CF_ZERO, CF_ZERO, CF_ZERO, CF_ZERO, CF_ZERO, CF_P1 },
    '{CF_ZERO, CF_ZERO, CF_ZERO, CF_P1,   CF_ZERO, CF_PMU},
    '{CF_ZERO, CF_ZERO, CF_ZERO, CF_N1,   CF_ZERO, CF_PMU},
    '{CF_ZERO, CF_ZERO, CF_ZERO, CF_ZERO, CF_P1,   CF_PMU},
    '{CF_ZERO, CF_ZERO, CF_ZERO, CF_ZERO, CF_N1,   CF_PMU},
    '{CF_P1,   CF_ZERO, CF_ZERO, CF_ZERO, CF_ZERO, CF_PY },
    '{CF_N1,   CF_ZERO, CF_ZERO, CF_ZERO, CF_ZERO, CF_PY },
    '{CF_ZERO, CF_P1,   CF_ZERO, CF_ZERO, CF_ZERO, CF_PX },
    '{CF_ZERO, CF_N1,   CF_ZERO, CF_ZERO, CF_ZERO, CF_PX },
    '{CF_NMU,  CF_NMU,  CF_P1,   CF_PY,   CF_PX,   CF_MXY},
    '{CF_NMU,  CF_PMU,  CF_P1,   CF_PY,   CF_NX,   CF_MXY},
    '{CF_PMU,  CF_NMU,  CF_P1,   CF_NY,   CF_PX,   CF_MXY},
    '{CF_PMU,  CF_PMU,  CF_P1,   CF_NY,   CF_NX,   CF_MXY},
    '{CF_NMU,  CF_NMU,  CF_N1,   CF_NY,   CF_NX,   CF_MXY},
    '{CF_NMU,  CF_PMU,  CF_N1,   CF_NY,   CF_PX,   CF_MXY},
    '{CF_PMU,  CF_NMU,  CF_N1,   CF_PY,   CF_NX,   CF_MXY},
    '{CF_PMU,  CF_PMU,  CF_N1,   CF_PY,   CF_PX,   CF_MXY}
  };

  function automatic acc_t term_sel(coef_e code, acc_t p, acc_t m, acc_t xt, acc_t yt,
                                    acc_t k);
    acc_t r;
    case (code)
      CF_ZERO: r = '0;
      CF_P1:   r = p;
      CF_N1:   r = -p;
      CF_PMU:  r = m;
      CF_NMU:  r = -m;
      CF_PX:   r = xt;
      CF_NX:   r = -xt;
      CF_PY:   r = yt;
      CF_NY:   r = -yt;
      CF_MXY:  r = k;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/cwcr_if.sv
// valid/ready channels of the contact wrench cone residual block
// depends on cwcr_pkg for field widths
interface cwcr_wrench_if #(
  parameter int WRENCH_BITS = 32
);
  logic                                  valid;
  logic                                  ready;
  logic signed [cwcr_pkg::QuatW-1:0]     quat_w;
  logic signed [cwcr_pkg::QuatW-1:0]     quat_x;
  logic signed [cwcr_pkg::QuatW-1:0]     quat_y;
  logic signed [cwcr_pkg::QuatW-1:0]     quat_z;
  logic signed [WRENCH_BITS-1:0]         torque_x;
  logic signed [WRENCH_BITS-1:0]         torque_y;
  logic signed [WRENCH_BITS-1:0]         torque_z;
  logic signed [WRENCH_BITS-1:0]         force_x;
  logic signed [WRENCH_BITS-1:0]         force_y;
  logic signed [WRENCH_BITS-1:0]         force_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, torque_x, torque_y,
                  torque_z, force_x, force_y, force_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, torque_x, torque_y,
                torque_z, force_x, force_y, force_z, output ready);
endinterface

interface cwcr_row_if;
  logic                               valid;
  logic                               ready;
  logic [cwcr_pkg::RowW-1:0]          row_index;
  logic signed [cwcr_pkg::OutW-1:0]   constraint_value;
  logic                               last_row;

  modport source (output valid, row_index, constraint_value, last_row, input ready);
  modport sink (input valid, row_index, constraint_value, last_row, output ready);
endinterface

FILE: hw/rtl/cwcr_rotate.sv
// rotation of both wrench halves into the link frame, four register stages
// depends on cwcr_pkg
module cwcr_rotate #(
  parameter int WRENCH_BITS    = 32,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [3:0][cwcr_pkg::QuatW-1:0]         quat_i,
  input  logic [cwcr_pkg::WrenchDim-1:0][WRENCH_BITS-1:0] wrench_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output cwcr_pkg::wrench_vec_t                   vec_o
);

  localparam int QS = 2 * QUAT_FRAC_BITS;
  localparam int RW = ((QS + 2 > 34) ? QS + 2 : 34) + 1;
  localparam int PW = RW + WRENCH_BITS;
  localparam int SW = PW + 2;
  localparam int EW = (SW > 65) ? SW : 65;
  localparam logic signed [RW-1:0] One  = RW'(1) <<< QS;
  localparam logic signed [SW-1:0] Half = SW'(1) <<< (QS - 1);
  localparam logic signed [EW-1:0] VLim = EW'(1) <<< 62;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic go1, go2, go3, go4;

  logic signed [cwcr_pkg::QuatW-1:0] q1_q [4];
  logic signed [WRENCH_BITS-1:0]     w1_q [cwcr_pkg::WrenchDim];
  logic signed [WRENCH_BITS-1:0]     w2_q [cwcr_pkg::WrenchDim];
  logic signed [RW-1:0]              rm_d [3][3];
  logic signed [RW-1:0]              rm_q [3][3];
  logic signed [PW-1:0]              prod_q [2][3][3];
  cwcr_pkg::wrench_vec_t             vec_d, vec_q;

  assign go4 = !s4_v_q || out_ready_i;
  assign go3 = !s3_v_q || go4;
  assign go2 = !s2_v_q || go3;
  assign go1 = !s1_v_q || go2;
  assign in_ready_o  = go1;
  assign out_valid_o = s4_v_q;
  assign vec_o       = vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (go1) s1_v_q <= in_valid_i;
      if (go2) s2_v_q <= s1_v_q;
      if (go3) s3_v_q <= s2_v_q;
      if (go4) s4_v_q <= s3_v_q;
    end
  end

  // rotation matrix entries
  always_comb begin
    logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    xx = q1_q[1] * q1_q[1];
    yy = q1_q[2] * q1_q[2];
    zz = q1_q[3] * q1_q[3];
    xy = q1_q[1] * q1_q[2];
    xz = q1_q[1] * q1_q[3];
    yz = q1_q[2] * q1_q[3];
    wx = q1_q[0] * q1_q[1];
    wy = q1_q[0] * q1_q[2];
    wz = q1_q[0] * q1_q[3];
    rm_d[0][0] = One - ((RW'(yy) + RW'(zz)) <<< 1);
    rm_d[0][1] = (RW'(xy) - RW'(wz)) <<< 1;
    rm_d[0][2] = (RW'(xz) + RW'(wy)) <<< 1;
    rm_d[1][0] = (RW'(xy) + RW'(wz)) <<< 1;
    rm_d[1][1] = One - ((RW'(xx) + RW'(zz)) <<< 1);
    rm_d[1][2] = (RW'(yz) - RW'(wx)) <<< 1;
    rm_d[2][0] = (RW'(xz) - RW'(wy)) <<< 1;
    rm_d[2][1] = (RW'(yz) + RW'(wx)) <<< 1;
    rm_d[2][2] = One - ((RW'(xx) + RW'(yy)) <<< 1);
  end

  // sum, round and saturate each rotated component
  always_comb begin
    logic signed [SW-1:0] sum;
    logic signed [EW-1:0] ext;
    vec_d = '0;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        sum = SW'(prod_q[k][i][0]) + SW'(prod_q[k][i][1]) + SW'(prod_q[k][i][2]) + Half;
        sum = sum >>> QS;
        ext = EW'(sum);
        if (ext > VLim) ext = VLim;
        else if (ext < -VLim) ext = -VLim;
        vec_d[3*k+i] = ext[cwcr_pkg::VecW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go1) begin
      for (int i = 0; i < 4; i++) q1_q[i] <= $signed(quat_i[i]);
      for (int i = 0; i < cwcr_pkg::WrenchDim; i++) w1_q[i] <= $signed(wrench_i[i]);
    end
    if (go2) begin
      rm_q <= rm_d;
      w2_q <= w1_q;
    end
    if (go3) begin
      for (int k = 0; k < 2; k++)
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            prod_q[k][i][j] <= PW'(rm_q[j][i]) * PW'(w2_q[3*k+j]);
    end
    if (go4) vec_q <= vec_d;
  end

endmodule

FILE: hw/rtl/contact_wrench_cone_residual.sv
// contact wrench cone residual: top level with configuration registers,
// cone coefficient products and the row generator; uses cwcr_pkg, cwcr_if, cwcr_rotate
//
// Usage: one word on wrench_in carries a world-frame wrench and the link
// quaternion. For every word the block sends 17 words on row_out, rows 0 to
// 16 in order, last_row set on row 16. Each row value is the linearized
// cone row times the link-frame wrench, Q.8, saturated to 40 bits.
// Configuration (friction coefficient, x and y half widths) is written
// through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while
// no word is in flight, which the block itself does not enforce.
// Throughput: one row per cycle on row_out while the receiver is ready;
// the output port is the limit. Up to five words are buffered in the
// rotation and product stages while rows of an earlier word drain.
// Reset clears all valid bits and loads the default configuration.
// When the receiver stalls, the row stages hold and wrench_in.ready drops
// once every stage is full; nothing is lost or repeated.
module contact_wrench_cone_residual #(
  parameter int WRENCH_BITS    = 32,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cwcr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [cwcr_pkg::CfgW-1:0]        cfg_data_i,
  cwcr_wrench_if.sink                      wrench_in,
  cwcr_row_if.source                       row_out
);

  localparam int NP = cwcr_pkg::NumProd;
  localparam cwcr_pkg::acc_t HalfC  = cwcr_pkg::acc_t'(1) <<< (cwcr_pkg::CoefFrac - 1);
  localparam cwcr_pkg::acc_t OutMax =
    (cwcr_pkg::acc_t'(1) <<< (cwcr_pkg::OutW - 1)) - cwcr_pkg::acc_t'(1);
  localparam cwcr_pkg::acc_t OutMin = -(cwcr_pkg::acc_t'(1) <<< (cwcr_pkg::OutW - 1));

  logic [cwcr_pkg::CfgW-1:0]  mu_q, xh_q, yh_q;
  logic [cwcr_pkg::CoefW-1:0] kxy_q;

  logic                  rot_v, rot_ready;
  cwcr_pkg::wrench_vec_t rot_vec;

  logic s4_v_q, s5_v_q, r1_v_q, o_v_q;
  logic go_s4, go_s5, go_r1, go_r2, issue, s5_done;
  logic [cwcr_pkg::RowW-1:0] row_q, r1_row_q, o_row_q;

  logic [cwcr_pkg::CoefW-1:0] pc [NP];
  logic signed [cwcr_pkg::VecW-1:0] pv [NP];
  logic signed [cwcr_pkg::PpW-1:0] pl_q [NP];
  logic signed [cwcr_pkg::PpW-1:0] ph_q [NP];
  cwcr_pkg::acc_t term_q [NP];
  cwcr_pkg::wrench_vec_t vec4_q, vec5_q;
  cwcr_pkg::acc_t t [cwcr_pkg::WrenchDim];
  cwcr_pkg::acc_t s0_q, s1_q, s2_q;
  logic signed [cwcr_pkg::OutW-1:0] val_d, o_val_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q <= 16'd8192;
      xh_q <= 16'd6554;
      yh_q <= 16'd6554;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cwcr_pkg::REG_FRICTION: mu_q <= cfg_data_i;
        cwcr_pkg::REG_X_HALF:   xh_q <= cfg_data_i;
        cwcr_pkg::REG_Y_HALF:   yh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    kxy_q <= cwcr_pkg::CoefW'(mu_q) * (cwcr_pkg::CoefW'(xh_q) + cwcr_pkg::CoefW'(yh_q));
  end

  cwcr_rotate #(
    .WRENCH_BITS    (WRENCH_BITS),
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (wrench_in.valid),
    .in_ready_o  (wrench_in.ready),
    .quat_i      ({wrench_in.quat_z, wrench_in.quat_y, wrench_in.quat_x, wrench_in.quat_w}),
    .wrench_i    ({wrench_in.force_z, wrench_in.force_y, wrench_in.force_x,
                   wrench_in.torque_z, wrench_in.torque_y, wrench_in.torque_x}),
    .out_valid_o (rot_v),
    .out_ready_i (rot_ready),
    .vec_o       (rot_vec)
  );

  // flow control
  assign go_r2     = !o_v_q || row_out.ready;
  assign go_r1     = !r1_v_q || go_r2;
  assign issue     = s5_v_q && go_r1;
  assign s5_done   = issue && (row_q == cwcr_pkg::LastRow);
  assign go_s5     = !s5_v_q || s5_done;
  assign go_s4     = !s4_v_q || go_s5;
  assign rot_ready = go_s4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      r1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
      row_q  <= '0;
    end else begin
      if (go_s4) s4_v_q <= rot_v;
      if (go_s5) s5_v_q <= s4_v_q;
      if (go_r1) r1_v_q <= issue;
      if (go_r2) o_v_q  <= r1_v_q;
      if (issue) row_q  <= s5_done ? '0 : row_q + 1'b1;
    end
  end

  // coefficient and wrench operands of each product
  always_comb begin
    pc[cwcr_pkg::PrMtx] = cwcr_pkg::CoefW'(mu_q);
    pc[cwcr_pkg::PrMty] = cwcr_pkg::CoefW'(mu_q);
    pc[cwcr_pkg::PrMfz] = cwcr_pkg::CoefW'(mu_q);
    pc[cwcr_pkg::PrXfy] = cwcr_pkg::CoefW'(xh_q);
    pc[cwcr_pkg::PrXfz] = cwcr_pkg::CoefW'(xh_q);
    pc[cwcr_pkg::PrYfx] = cwcr_pkg::CoefW'(yh_q);
    pc[cwcr_pkg::PrYfz] = cwcr_pkg::CoefW'(yh_q);
    pc[cwcr_pkg::PrKfz] = kxy_q;
    pv[cwcr_pkg::PrMtx] = $signed(rot_vec[cwcr_pkg::ColTx]);
    pv[cwcr_pkg::PrMty] = $signed(rot_vec[cwcr_pkg::ColTy]);
    pv[cwcr_pkg::PrMfz] = $signed(rot_vec[cwcr_pkg::ColFz]);
    pv[cwcr_pkg::PrXfy] = $signed(rot_vec[cwcr_pkg::ColFy]);
    pv[cwcr_pkg::PrXfz] = $signed(rot_vec[cwcr_pkg::ColFz]);
    pv[cwcr_pkg::PrYfx] = $signed(rot_vec[cwcr_pkg::ColFx]);
    pv[cwcr_pkg::PrYfz] = $signed(rot_vec[cwcr_pkg::ColFz]);
    pv[cwcr_pkg::PrKfz] = $signed(rot_vec[cwcr_pkg::ColFz]);
  end

  // row terms
  always_comb begin
    cwcr_pkg::acc_t p [cwcr_pkg::WrenchDim];
    for (int j = 0; j < cwcr_pkg::WrenchDim; j++)
      p[j] = cwcr_pkg::acc_t'($signed(vec5_q[j])) <<< cwcr_pkg::CoefFrac;
    t[cwcr_pkg::ColTx] = cwcr_pkg::term_sel(cwcr_pkg::ConeCode[row_q][cwcr_pkg::ColTx],
      p[cwcr_pkg::ColTx], term_q[cwcr_pkg::PrMtx], '0, '0, '0);
    t[cwcr_pkg::ColTy] = cwcr_pkg::term_sel(cwcr_pkg::ConeCode[row_q][cwcr_pkg::ColTy],
      p[cwcr_pkg::ColTy], term_q[cwcr_pkg::PrMty], '0, '0, '0);
    t[cwcr_pkg::ColTz] = cwcr_pkg::term_sel(cwcr_pkg::ConeCode[row_q][cwcr_pkg::ColTz],
      p[cwcr_pkg::ColTz], '0, '0, '0, '0);
    t[cwcr_pkg::ColFx] = cwcr_pkg::term_sel(cwcr_pkg::ConeCode[row_q][cwcr_pkg::ColFx],
      p[cwcr_pkg::ColFx], '0, '0, term_q[cwcr_pkg::PrYfx], '0);
    t[cwcr_pkg::ColFy] = cwcr_pkg::term_sel(cwcr_pkg::ConeCode[row_q][cwcr_pkg::ColFy],
      p[cwcr_pkg::ColFy], '0, term_q[cwcr_pkg::PrXfy], '0, '0);
    t[cwcr_pkg::ColFz] = cwcr_pkg::term_sel(cwcr_pkg::ConeCode[row_q][cwcr_pkg::ColFz],
      p[cwcr_pkg::ColFz], term_q[cwcr_pkg::PrMfz], term_q[cwcr_pkg::PrXfz],
      term_q[cwcr_pkg::PrYfz], term_q[cwcr_pkg::PrKfz]);
  end

  // final sum, round and saturate
  always_comb begin
    cwcr_pkg::acc_t sum;
    sum = s0_q + s1_q + s2_q + HalfC;
    sum = sum >>> cwcr_pkg::CoefFrac;
    if (sum > OutMax) sum = OutMax;
    else if (sum < OutMin) sum = OutMin;
    val_d = sum[cwcr_pkg::OutW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (go_s4) begin
      for (int k = 0; k < NP; k++) begin
        pl_q[k] <= $signed({1'b0, pc[k]}) * $signed({1'b0, pv[k][31:0]});
        ph_q[k] <= $signed({1'b0, pc[k]}) * $signed(pv[k][cwcr_pkg::VecW-1:32]);
      end
      vec4_q <= rot_vec;
    end
    if (go_s5) begin
      for (int k = 0; k < NP; k++)
        term_q[k] <= ((cwcr_pkg::acc_t'(ph_q[k]) <<< 32) + cwcr_pkg::acc_t'(pl_q[k]))
                     <<< cwcr_pkg::PrShift[k];
      vec5_q <= vec4_q;
    end
    if (go_r1) begin
      s0_q     <= t[0] + t[1];
      s1_q     <= t[2] + t[3];
      s2_q     <= t[4] + t[5];
      r1_row_q <= row_q;
    end
    if (go_r2) begin
      o_val_q <= val_d;
      o_row_q <= r1_row_q;
    end
  end

  assign row_out.valid            = o_v_q;
  assign row_out.row_index        = o_row_q;
  assign row_out.constraint_value = o_val_q;
  assign row_out.last_row         = (o_row_q == cwcr_pkg::LastRow);

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= cwcr_pkg::LastRow)
    else $error("row counter out of range");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_v_q && row_out.ready && o_row_q != cwcr_pkg::LastRow) |=>
      (!o_v_q || o_row_q == $past(o_row_q) + 1'b1))
    else $error("rows out of order");

  a_word_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_v_q && issue && row_q != cwcr_pkg::LastRow) |=> s5_v_q)
    else $error("word released before its last row");

endmodule
